// ===== hdl/plr_pkg.sv =====
// Shared types, constants and brush tables for the patterned line rasterizer.
// Used by plr_stamp, patterned_line_rasterizer and plr_checker; no dependencies.
`timescale 1ns / 1ps

package plr_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int GRID_MAX_DEF   = 512;

  localparam int CFG_W   = 10;  // widest configuration register
  localparam int PIX_W   = 9;   // pixel_col / pixel_row width
  localparam int BRUSH_W = 3;
  localparam int OUT_W   = 24;  // two pixel fields, padded to whole bytes
  localparam int IDX_W   = 4;   // brush slot index, up to eight neighbours plus centre

  localparam logic [15:0] GRID_COLS_RST = 16'd16;
  localparam logic [15:0] GRID_ROWS_RST = 16'd16;

  // Input kinds carried on tuser
  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_GRID_COLUMNS = 2'd0;
  localparam logic [1:0] CFG_GRID_ROWS    = 2'd1;
  localparam logic [1:0] CFG_OFFSET_X     = 2'd2;
  localparam logic [1:0] CFG_OFFSET_Y     = 2'd3;

  // Brush codes
  localparam logic [BRUSH_W-1:0] BRUSH_HORIZ  = 3'd1;
  localparam logic [BRUSH_W-1:0] BRUSH_VERT   = 3'd2;
  localparam logic [BRUSH_W-1:0] BRUSH_CROSS  = 3'd3;
  localparam logic [BRUSH_W-1:0] BRUSH_SQUARE = 3'd4;

  typedef enum logic [1:0] {
    OCT_SHALLOW_UP   = 2'd0,
    OCT_STEEP_UP     = 2'd1,
    OCT_SHALLOW_DOWN = 2'd2,
    OCT_STEEP_DOWN   = 2'd3
  } oct_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWAP,
    ST_SETUP,
    ST_ADVANCE,
    ST_LAUNCH,
    ST_STAMP
  } line_state_t;

  typedef enum logic [1:0] {
    SP_IDLE,
    SP_RUN,
    SP_FLUSH
  } stamp_state_t;

  typedef struct packed {
    logic signed [1:0] dx;
    logic signed [1:0] dy;
  } brush_off_t;

  typedef struct packed {
    logic               start;
    logic [BRUSH_W-1:0] kind;
    logic               line_end;
  } stamp_ctl_t;

  typedef struct packed {
    logic busy;
  } stamp_stat_t;

  // Number of neighbour pixels stamped before the centre
  function automatic logic [IDX_W-1:0] brush_count(input logic [BRUSH_W-1:0] kind);
    logic [IDX_W-1:0] n;
    unique case (kind)
      BRUSH_HORIZ:  n = 4'd2;
      BRUSH_VERT:   n = 4'd2;
      BRUSH_CROSS:  n = 4'd4;
      BRUSH_SQUARE: n = 4'd8;
      default:      n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic brush_off_t mk_off(input int x, input int y);
    brush_off_t o;
    o.dx = 2'(x);
    o.dy = 2'(y);
    return o;
  endfunction

  // Offset of slot idx; slots past the brush are the centre
  function automatic brush_off_t brush_offset(input logic [BRUSH_W-1:0] kind,
                                              input logic [IDX_W-1:0]   idx);
    brush_off_t o;
    o = mk_off(0, 0);
    unique case (kind)
      BRUSH_HORIZ: begin
        if (idx == 4'd0) o = mk_off(-1, 0);
        else if (idx == 4'd1) o = mk_off(1, 0);
      end
      BRUSH_VERT: begin
        if (idx == 4'd0) o = mk_off(0, -1);
        else if (idx == 4'd1) o = mk_off(0, 1);
      end
      BRUSH_CROSS: begin
        unique case (idx)
          4'd0:    o = mk_off(0, -1);
          4'd1:    o = mk_off(0, 1);
          4'd2:    o = mk_off(-1, 0);
          4'd3:    o = mk_off(1, 0);
          default: o = mk_off(0, 0);
        endcase
      end
      BRUSH_SQUARE: begin
        unique case (idx)
          4'd0:    o = mk_off(-1, -1);
          4'd1:    o = mk_off(0, -1);
          4'd2:    o = mk_off(1, -1);
          4'd3:    o = mk_off(-1, 0);
          4'd4:    o = mk_off(1, 0);
          4'd5:    o = mk_off(0, 1);
          4'd6:    o = mk_off(-1, 1);
          4'd7:    o = mk_off(1, 1);
          default: o = mk_off(0, 0);
        endcase
      end
      default: o = mk_off(0, 0);
    endcase
    return o;
  endfunction

endpackage

// ===== hdl/plr_stamp.sv =====
// Brush stamper: walks the brush slots of one line point through a single
// offset-add and grid-clip unit, one slot per cycle while the output does not stall. Depends on plr_pkg.
`timescale 1ns / 1ps

module plr_stamp #(
  parameter int COORD_BITS = plr_pkg::COORD_BITS_DEF,
  parameter int GRID_MAX   = plr_pkg::GRID_MAX_DEF,
  parameter int POS_W      = COORD_BITS + 6
) (
  input  logic                              clk,
  input  logic                              rst,
  input  plr_pkg::stamp_ctl_t               ctl,
  output plr_pkg::stamp_stat_t              stat,
  input  logic signed [POS_W-1:0]           pos_x,
  input  logic signed [POS_W-1:0]           pos_y,
  input  logic [plr_pkg::CFG_W-1:0]         grid_columns,
  input  logic [plr_pkg::CFG_W-1:0]         grid_rows,
  input  logic signed [plr_pkg::CFG_W-1:0]  offset_x,
  input  logic signed [plr_pkg::CFG_W-1:0]  offset_y,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [plr_pkg::OUT_W-1:0]         m_axis_tdata,  // pixel_col, pixel_row
  output logic                              m_axis_tlast,  // last_of_point
  output logic                              m_axis_tuser   // last_of_line
);
  import plr_pkg::*;

  localparam int SUM_W = (POS_W + 2 > 17) ? POS_W + 2 : 17;

  stamp_state_t st, st_next;

  logic [IDX_W-1:0]        idx;
  logic [IDX_W-1:0]        cnt;
  logic [BRUSH_W-1:0]      kind;
  logic                    line_end;
  logic signed [POS_W-1:0] px, py;

  logic             pend_valid;
  logic [PIX_W-1:0] pend_col, pend_row;

  logic             out_valid, out_last, out_line;
  logic [PIX_W-1:0] out_col, out_row;

  brush_off_t              off;
  logic signed [1:0]       odx, ody;
  logic signed [SUM_W-1:0] col, row, ncols, nrows, gmax, gcols, grows;
  logic                    hit, out_free, step_ok, last_slot;
  logic                    out_load, out_load_last, pend_load, pend_clear;

  // Shared offset-add and clip unit
  always_comb begin
    off   = brush_offset(kind, idx);
    odx   = off.dx;
    ody   = off.dy;
    col   = SUM_W'(px) + SUM_W'(odx) + SUM_W'(offset_x);
    row   = SUM_W'(py) + SUM_W'(ody) + SUM_W'(offset_y);
    gmax  = SUM_W'(GRID_MAX);
    gcols = SUM_W'({1'b0, grid_columns});
    grows = SUM_W'({1'b0, grid_rows});
    ncols = (gcols > gmax) ? gmax : gcols;
    nrows = (grows > gmax) ? gmax : grows;
    hit   = !col[SUM_W-1] && !row[SUM_W-1] && (col < ncols) && (row < nrows);
    cnt   = brush_count(kind);
    last_slot = (idx == cnt);
  end

  always_comb begin
    st_next = st;
    unique case (st)
      SP_IDLE:  if (ctl.start) st_next = SP_RUN;
      SP_RUN:   if (step_ok && last_slot) st_next = SP_FLUSH;
      SP_FLUSH: if (!pend_valid || out_free) st_next = SP_IDLE;
      default:  st_next = SP_IDLE;
    endcase
  end

  // One pixel waits in the pending slot until the next hit or the end of
  // the point shows whether it is the last one
  always_comb begin
    out_free      = !out_valid || m_axis_tready;
    step_ok       = 1'b0;
    out_load      = 1'b0;
    out_load_last = 1'b0;
    pend_load     = 1'b0;
    pend_clear    = 1'b0;
    unique case (st)
      SP_RUN: begin
        step_ok   = !(hit && pend_valid && !out_free);
        out_load  = step_ok && hit && pend_valid;
        pend_load = step_ok && hit;
      end
      SP_FLUSH: begin
        out_load      = pend_valid && out_free;
        out_load_last = 1'b1;
        pend_clear    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= SP_IDLE;
      idx        <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      st <= st_next;
      if (st == SP_IDLE && ctl.start) begin
        idx      <= '0;
        kind     <= ctl.kind;
        line_end <= ctl.line_end;
        px       <= pos_x;
        py       <= pos_y;
      end else if (st == SP_RUN && step_ok) begin
        idx <= idx + 1'b1;
      end

      if (pend_load) begin
        pend_valid <= 1'b1;
        pend_col   <= col[PIX_W-1:0];
        pend_row   <= row[PIX_W-1:0];
      end else if (pend_clear && out_free) begin
        pend_valid <= 1'b0;
      end

      if (out_load) begin
        out_valid <= 1'b1;
        out_col   <= pend_col;
        out_row   <= pend_row;
        out_last  <= out_load_last;
        out_line  <= line_end;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign stat.busy     = (st != SP_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OUT_W - 2 * PIX_W)'(0), out_row, out_col};
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_line;

endmodule

// ===== hdl/patterned_line_rasterizer.sv =====
// Top level of the patterned line rasterizer: line setup, midpoint stepping,
// grid configuration and the stream ports. Depends on plr_pkg and plr_stamp.
`timescale 1ns / 1ps

// A begin transfer (tuser low) loads two endpoints and a brush, then passes
// through the swap and setup states; it produces no pixels. A step transfer
// (tuser high) moves to the next line point (the start point on the first
// step) and streams the brush pixels followed by the centre, dropping any
// that land off the grid; tlast marks the last pixel sent for the point,
// tuser marks every pixel of the line's final point. A point has n brush
// slots, n being the brush size plus one (1, 3, 5 or 9), and one offset-add
// and clip unit handles one brush slot per cycle while the output does not
// stall. A step with no line loaded is taken and produces no pixels. The
// pixel output is registered, so a new item is taken while the last pixel of
// the previous one still waits to be transferred.

module patterned_line_rasterizer #(
  parameter int COORD_BITS = plr_pkg::COORD_BITS_DEF,
  parameter int GRID_MAX   = plr_pkg::GRID_MAX_DEF,
  parameter int IN_W       = ((4 * COORD_BITS + plr_pkg::BRUSH_W + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [IN_W-1:0]               s_axis_tdata,  // x_start, y_start, x_end, y_end, brush
  input  logic                          s_axis_tuser,  // op
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [plr_pkg::OUT_W-1:0]     m_axis_tdata,  // pixel_col, pixel_row
  output logic                          m_axis_tlast,  // last_of_point
  output logic                          m_axis_tuser,  // last_of_line
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [plr_pkg::CFG_W-1:0]     cfg_data
);
  import plr_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int POS_W = COORD_BITS + 6;

  line_state_t state, state_next;

  logic [CFG_W-1:0]        grid_columns, grid_rows;
  logic signed [CFG_W-1:0] offset_x, offset_y;

  logic signed [POS_W-1:0] cur_x, cur_y, stop_x, stop_y;
  logic signed [POS_W-1:0] dx_r, dy_r;
  logic signed [POS_W-1:0] decision, step_inc_a, step_inc_b;
  oct_t                    octant_case;
  logic [BRUSH_W-1:0]      brush_kind;
  logic                    line_active, first_point;

  logic                    in_fire, op_begin;
  logic signed [POS_W-1:0] in_xs, in_ys, in_xe, in_ye;
  logic                    swap;
  logic signed [POS_W-1:0] ady, dx2, dy2;
  logic                    steep;
  oct_t                    oct_sel;
  logic signed [POS_W-1:0] init_d, init_a, init_b;
  logic                    use_a, move_x;
  logic signed [1:0]       move_y;
  logic signed [POS_W-1:0] dec_sum;
  logic                    line_done;

  stamp_ctl_t  sctl;
  stamp_stat_t sstat;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign op_begin = (s_axis_tuser == OP_BEGIN);
  assign in_xs = POS_W'(signed'(s_axis_tdata[CB-1:0]));
  assign in_ys = POS_W'(signed'(s_axis_tdata[2*CB-1:CB]));
  assign in_xe = POS_W'(signed'(s_axis_tdata[3*CB-1:2*CB]));
  assign in_ye = POS_W'(signed'(s_axis_tdata[4*CB-1:3*CB]));

  // Octant selection and starting decision terms
  always_comb begin
    swap  = cur_x > stop_x;
    ady   = dy_r[POS_W-1] ? -dy_r : dy_r;
    steep = dx_r < ady;
    dx2   = dx_r <<< 1;
    dy2   = dy_r <<< 1;
    unique case ({dy_r[POS_W-1], steep})
      2'b00:   oct_sel = OCT_SHALLOW_UP;
      2'b01:   oct_sel = OCT_STEEP_UP;
      2'b10:   oct_sel = OCT_SHALLOW_DOWN;
      default: oct_sel = OCT_STEEP_DOWN;
    endcase
    unique case (oct_sel)
      OCT_SHALLOW_UP: begin
        init_d = dy2 - dx_r;  init_a = dy2;  init_b = dy2 - dx2;
      end
      OCT_STEEP_UP: begin
        init_d = dy_r - dx2;  init_a = -dx2; init_b = dy2 - dx2;
      end
      OCT_SHALLOW_DOWN: begin
        init_d = dy2 + dx_r;  init_a = dy2;  init_b = dy2 + dx2;
      end
      default: begin
        init_d = dy_r + dx2;  init_a = dx2;  init_b = dx2 + dy2;
      end
    endcase
  end

  // Midpoint step decision
  always_comb begin
    unique case (octant_case)
      OCT_SHALLOW_UP: begin
        use_a = (decision <= 0); move_x = 1'b1;  move_y = use_a ? 2'sd0 : 2'sd1;
      end
      OCT_STEEP_UP: begin
        use_a = (decision > 0);  move_x = !use_a; move_y = 2'sd1;
      end
      OCT_SHALLOW_DOWN: begin
        use_a = (decision > 0);  move_x = 1'b1;  move_y = use_a ? 2'sd0 : -2'sd1;
      end
      default: begin
        use_a = (decision < 0);  move_x = !use_a; move_y = -2'sd1;
      end
    endcase
    dec_sum = decision + (use_a ? step_inc_a : step_inc_b);
    unique case (octant_case)
      OCT_STEEP_UP:   line_done = (cur_y >= stop_y);
      OCT_STEEP_DOWN: line_done = (cur_y <= stop_y);
      default:        line_done = (cur_x >= stop_x);
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (op_begin) state_next = ST_SWAP;
          else if (line_active) state_next = first_point ? ST_LAUNCH : ST_ADVANCE;
        end
      end
      ST_SWAP:    state_next = ST_SETUP;
      ST_SETUP:   state_next = ST_IDLE;
      ST_ADVANCE: state_next = ST_LAUNCH;
      ST_LAUNCH:  state_next = ST_STAMP;
      ST_STAMP:   if (!sstat.busy) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    sctl.start    = (state == ST_LAUNCH);
    sctl.kind     = brush_kind;
    sctl.line_end = line_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      line_active  <= 1'b0;
      first_point  <= 1'b0;
      grid_columns <= GRID_COLS_RST[CFG_W-1:0];
      grid_rows    <= GRID_ROWS_RST[CFG_W-1:0];
      offset_x     <= '0;
      offset_y     <= '0;
      cur_x        <= '0;
      cur_y        <= '0;
      stop_x       <= '0;
      stop_y       <= '0;
      decision     <= '0;
      step_inc_a   <= '0;
      step_inc_b   <= '0;
      octant_case  <= OCT_SHALLOW_UP;
      brush_kind   <= '0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GRID_COLUMNS: grid_columns <= cfg_data;
          CFG_GRID_ROWS:    grid_rows    <= cfg_data;
          CFG_OFFSET_X:     offset_x     <= cfg_data;
          CFG_OFFSET_Y:     offset_y     <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (in_fire && op_begin) begin
            cur_x       <= in_xs;
            cur_y       <= in_ys;
            stop_x      <= in_xe;
            stop_y      <= in_ye;
            brush_kind  <= s_axis_tdata[4*CB+BRUSH_W-1:4*CB];
            line_active <= 1'b0;
          end
        end
        ST_SWAP: begin
          // order the endpoints so the column rises
          if (swap) begin
            cur_x  <= stop_x;
            cur_y  <= stop_y;
            stop_x <= cur_x;
            stop_y <= cur_y;
            dx_r   <= cur_x - stop_x;
            dy_r   <= cur_y - stop_y;
          end else begin
            dx_r <= stop_x - cur_x;
            dy_r <= stop_y - cur_y;
          end
        end
        ST_SETUP: begin
          octant_case <= oct_sel;
          decision    <= init_d;
          step_inc_a  <= init_a;
          step_inc_b  <= init_b;
          line_active <= 1'b1;
          first_point <= 1'b1;
        end
        ST_ADVANCE: begin
          decision <= dec_sum;
          cur_x    <= cur_x + POS_W'(move_x);
          cur_y    <= cur_y + POS_W'(move_y);
        end
        ST_LAUNCH: begin
          first_point <= 1'b0;
          if (line_done) line_active <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  plr_stamp #(
    .COORD_BITS (COORD_BITS),
    .GRID_MAX   (GRID_MAX),
    .POS_W      (POS_W)
  ) u_stamp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (sctl),
    .stat          (sstat),
    .pos_x         (cur_x),
    .pos_y         (cur_y),
    .grid_columns  (grid_columns),
    .grid_rows     (grid_rows),
    .offset_x      (offset_x),
    .offset_y      (offset_y),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== hdl/plr_checker.sv =====
// Port-level checks for the patterned line rasterizer, bound to the top level.
// Depends on plr_pkg.
`timescale 1ns / 1ps

module plr_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      s_axis_tuser,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [plr_pkg::OUT_W-1:0] m_axis_tdata,
  input logic                      m_axis_tlast,
  input logic                      m_axis_tuser
);
  import plr_pkg::*;

  // no pixel comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("pixel valid right after reset");

  // a begin transfer always occupies the block for its setup
  a_begin_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_BEGIN) |=> !s_axis_tready)
    else $error("input ready right after a begin transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("pixel dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      ($stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser)))
    else $error("pixel changed while stalled");

endmodule

bind patterned_line_rasterizer plr_checker u_plr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/sv/tb.sv =====
// Self-checking bench for patterned_line_rasterizer: drives begin/step transfers,
// predicts the stamped brush pixels of every line point and checks the pixel stream.
// Depends on plr_pkg and the rasterizer RTL.
`timescale 1ns / 1ps

module tb;
  import plr_pkg::*;

  localparam int CMD_W        = ((4 * COORD_BITS_DEF + BRUSH_W + 7) / 8) * 8;
  localparam int GRID_LIMIT   = GRID_MAX_DEF;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_CYCLES = 40;
  localparam int CALM_FROM    = 1500;
  localparam int CALM_TO      = 3500;
  localparam int HOLD_AFTER   = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int REPORT_MAX   = 10;

  // brush codes with no pattern: centre only
  localparam logic [BRUSH_W-1:0] BRUSH_PLAIN = 3'd0;
  localparam logic [BRUSH_W-1:0] BRUSH_SPARE = 3'd7;

  typedef struct {
    logic                      op;
    logic signed [9:0]         xs, ys, xe, ye;
    logic        [BRUSH_W-1:0] brush;
  } line_cmd_t;

  typedef struct {
    logic [PIX_W-1:0] col, row;
    logic             last_pt, last_line;
  } pixel_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [CMD_W-1:0]   s_axis_tdata = '0;  // x_start, y_start, x_end, y_end, brush
  logic               s_axis_tuser = 1'b0;  // op
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OUT_W-1:0]   m_axis_tdata;  // pixel_col, pixel_row
  logic               m_axis_tlast;  // last_of_point
  logic               m_axis_tuser;  // last_of_line
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = CFG_GRID_COLUMNS;
  logic [CFG_W-1:0]   cfg_data = '0;

  patterned_line_rasterizer dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  int cycle_cnt = 0;
  int err_cnt = 0;
  int seen_cnt = 0;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  line_cmd_t cmd_q[$];
  pixel_t    pending_pixels[$];
  pixel_t    stamp_buf[$];

  // Line state of the predictor
  logic signed [15:0]  pos_x, pos_y, end_x, end_y, dvar, inc_a, inc_b;
  oct_t                slope_kind;
  logic [BRUSH_W-1:0]  pen;
  bit                  active, fresh;
  // Grid registers as written
  logic [CFG_W-1:0]        grid_cols, grid_rows;
  logic signed [CFG_W-1:0] off_x, off_y;

  task automatic reset_model();
    pos_x = '0; pos_y = '0; end_x = '0; end_y = '0;
    dvar = '0; inc_a = '0; inc_b = '0;
    slope_kind = OCT_SHALLOW_UP;
    pen = BRUSH_PLAIN;
    active = 0;
    fresh = 0;
    grid_cols = CFG_W'(GRID_COLS_RST);
    grid_rows = CFG_W'(GRID_ROWS_RST);
    off_x = '0;
    off_y = '0;
  endtask

  task automatic load_line(input line_cmd_t c);
    int x0, y0, x1, y1, dx, dy, ady, t, dv, ia, ib;
    x0 = int'(c.xs); y0 = int'(c.ys); x1 = int'(c.xe); y1 = int'(c.ye);
    // walk with x rising
    if (x0 > x1) begin
      t = x0; x0 = x1; x1 = t;
      t = y0; y0 = y1; y1 = t;
    end
    dx = x1 - x0;
    dy = y1 - y0;
    ady = (dy < 0) ? -dy : dy;
    if (dy >= 0 && dx >= ady) begin
      slope_kind = OCT_SHALLOW_UP;
      dv = 2 * dy - dx; ia = 2 * dy; ib = 2 * (dy - dx);
    end else if (dy >= 0) begin
      slope_kind = OCT_STEEP_UP;
      dv = dy - 2 * dx; ia = -2 * dx; ib = 2 * (dy - dx);
    end else if (dx >= ady) begin
      slope_kind = OCT_SHALLOW_DOWN;
      dv = 2 * dy + dx; ia = 2 * dy; ib = 2 * (dy + dx);
    end else begin
      slope_kind = OCT_STEEP_DOWN;
      dv = dy + 2 * dx; ia = 2 * dx; ib = 2 * (dx + dy);
    end
    dvar = 16'(dv); inc_a = 16'(ia); inc_b = 16'(ib);
    pos_x = 16'(x0); pos_y = 16'(y0);
    end_x = 16'(x1); end_y = 16'(y1);
    pen = c.brush;
    active = 1;
    fresh = 1;
  endtask

  // Shift by the grid offsets and keep the pixel only if it lands on the grid
  task automatic plot(input int px, input int py);
    int col, row, lim_c, lim_r;
    pixel_t p;
    col = px + int'(off_x);
    row = py + int'(off_y);
    lim_c = (grid_cols > GRID_LIMIT) ? GRID_LIMIT : int'(grid_cols);
    lim_r = (grid_rows > GRID_LIMIT) ? GRID_LIMIT : int'(grid_rows);
    if (col >= 0 && col < lim_c && row >= 0 && row < lim_r) begin
      p.col = col[PIX_W-1:0];
      p.row = row[PIX_W-1:0];
      p.last_pt = 1'b0;
      p.last_line = 1'b0;
      stamp_buf = {stamp_buf, p};
    end
  endtask

  task automatic trace_point();
    bit done;
    int cx, cy;
    stamp_buf.delete();
    if (!active) return;
    if (!fresh) begin
      case (slope_kind)
        OCT_SHALLOW_UP:
          if (dvar <= 0) begin dvar += inc_a; pos_x++; end
          else begin dvar += inc_b; pos_x++; pos_y++; end
        OCT_STEEP_UP:
          if (dvar > 0) begin dvar += inc_a; pos_y++; end
          else begin dvar += inc_b; pos_x++; pos_y++; end
        OCT_SHALLOW_DOWN:
          if (dvar > 0) begin dvar += inc_a; pos_x++; end
          else begin dvar += inc_b; pos_x++; pos_y--; end
        default:
          if (dvar < 0) begin dvar += inc_a; pos_y--; end
          else begin dvar += inc_b; pos_x++; pos_y--; end
      endcase
    end
    fresh = 0;
    cx = int'(pos_x);
    cy = int'(pos_y);
    case (pen)
      BRUSH_HORIZ: begin
        plot(cx - 1, cy); plot(cx + 1, cy);
      end
      BRUSH_VERT: begin
        plot(cx, cy - 1); plot(cx, cy + 1);
      end
      BRUSH_CROSS: begin
        plot(cx, cy - 1); plot(cx, cy + 1); plot(cx - 1, cy); plot(cx + 1, cy);
      end
      BRUSH_SQUARE: begin
        plot(cx - 1, cy - 1); plot(cx, cy - 1); plot(cx + 1, cy - 1);
        plot(cx - 1, cy);     plot(cx + 1, cy);
        plot(cx, cy + 1);     plot(cx - 1, cy + 1); plot(cx + 1, cy + 1);
      end
      default: ;
    endcase
    plot(cx, cy);
    case (slope_kind)
      OCT_STEEP_UP:   done = (pos_y >= end_y);
      OCT_STEEP_DOWN: done = (pos_y <= end_y);
      default:        done = (pos_x >= end_x);
    endcase
    if (done) active = 0;
    foreach (stamp_buf[k]) begin
      stamp_buf[k].last_line = done;
      stamp_buf[k].last_pt = (k == stamp_buf.size() - 1);
      pending_pixels = {pending_pixels, stamp_buf[k]};
    end
  endtask

  function automatic bit idle_now();
    return (cycle_cnt < CALM_FROM || cycle_cnt >= CALM_TO) && $urandom_range(0, 99) < 7;
  endfunction

  // Command driver: hold each transfer until taken, predict on acceptance
  line_cmd_t held;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      reset_model();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (held.op == OP_BEGIN) load_line(held);
        else trace_point();
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cmd_q.size() != 0 && !idle_now()) begin
          held = cmd_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {{(CMD_W - 43){1'b0}}, held.brush, held.ye, held.xe,
                           held.ys, held.xs};
          s_axis_tuser <= held.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Pixel monitor and receiver backpressure
  int     hold_left = 0;
  bit     hold_done = 0;
  pixel_t want;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen_cnt++;
        if (pending_pixels.size() == 0) begin
          err_cnt++;
          if (err_cnt <= REPORT_MAX)
            $display("unexpected pixel: col %0d row %0d last_pt %0b last_line %0b",
                     m_axis_tdata[8:0], m_axis_tdata[17:9], m_axis_tlast, m_axis_tuser);
        end else begin
          want = pending_pixels.pop_front();
          if (m_axis_tdata[8:0] !== want.col || m_axis_tdata[17:9] !== want.row ||
              m_axis_tlast !== want.last_pt || m_axis_tuser !== want.last_line) begin
            err_cnt++;
            if (err_cnt <= REPORT_MAX)
              $display("pixel mismatch: expected col %0d row %0d last_pt %0b last_line %0b, %s",
                       want.col, want.row, want.last_pt, want.last_line,
                       $sformatf("got col %0d row %0d last_pt %0b last_line %0b",
                                 m_axis_tdata[8:0], m_axis_tdata[17:9],
                                 m_axis_tlast, m_axis_tuser));
          end
        end
      end
      // one long hold-off so the block backs up into its input
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && seen_cnt >= HOLD_AFTER) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !idle_now();
      end
    end
  end

  task automatic push_cmd(input logic op, input int xs, input int ys, input int xe,
                          input int ye, input logic [BRUSH_W-1:0] br);
    line_cmd_t c;
    c.op = op;
    c.xs = 10'(xs); c.ys = 10'(ys); c.xe = 10'(xe); c.ye = 10'(ye);
    c.brush = br;
    cmd_q = {cmd_q, c};
  endtask

  task automatic push_steps(input int n);
    repeat (n) push_cmd(OP_STEP, $urandom, $urandom, $urandom, $urandom,
                        BRUSH_W'($urandom));
  endtask

  function automatic int fit_coord(input int v);
    if (v < -512) return -512;
    if (v > 511) return 511;
    return v;
  endfunction

  // Pick a coordinate near either grid edge or inside, in line space
  function automatic int anchor(input int lim, input int off);
    int r, a;
    r = $urandom_range(0, 2);
    if (r == 0) a = int'($urandom_range(0, 3)) - 2;
    else if (r == 1) a = lim - 2 + int'($urandom_range(0, 3));
    else a = int'($urandom_range(0, lim - 1));
    return fit_coord(a - off);
  endfunction

  task automatic random_lines(input int budget);
    int used, mode, r, x0, y0, x1, y1, len, dxa, dya, npts, nsteps, lc, lr;
    used = 0;
    lc = (grid_cols == 0) ? 16 : ((grid_cols > GRID_LIMIT) ? GRID_LIMIT : int'(grid_cols));
    lr = (grid_rows == 0) ? 16 : ((grid_rows > GRID_LIMIT) ? GRID_LIMIT : int'(grid_rows));
    while (used < budget) begin
      mode = $urandom_range(0, 99);
      if (mode < 8) begin
        // noise: any op, any field values
        push_cmd(1'($urandom), $urandom, $urandom, $urandom, $urandom,
                 BRUSH_W'($urandom));
        used++;
      end else begin
        if (mode < 15) begin
          // anywhere in the coordinate range; dropped after a few points
          x0 = int'($urandom_range(0, 1023)) - 512;
          y0 = int'($urandom_range(0, 1023)) - 512;
          x1 = int'($urandom_range(0, 1023)) - 512;
          y1 = int'($urandom_range(0, 1023)) - 512;
          nsteps = $urandom_range(1, 3);
        end else begin
          x0 = anchor(lc, int'(off_x));
          y0 = anchor(lr, int'(off_y));
          len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 6);
          x1 = fit_coord(x0 + int'($urandom_range(0, 2 * len)) - len);
          y1 = fit_coord(y0 + int'($urandom_range(0, 2 * len)) - len);
          dxa = (x1 > x0) ? x1 - x0 : x0 - x1;
          dya = (y1 > y0) ? y1 - y0 : y0 - y1;
          npts = ((dxa > dya) ? dxa : dya) + 1;
          nsteps = npts;
          r = $urandom_range(0, 9);
          // cut short so the next begin replaces it, or step past the end
          if (r == 0) nsteps = $urandom_range(0, npts - 1);
          else if (r == 1) nsteps = npts + 1;
        end
        push_cmd(OP_BEGIN, x0, y0, x1, y1, BRUSH_W'($urandom_range(0, 7)));
        push_steps(nsteps);
        used += 1 + nsteps;
      end
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_GRID_COLUMNS: grid_cols = val;
      CFG_GRID_ROWS:    grid_rows = val;
      CFG_OFFSET_X:     off_x = signed'(val);
      CFG_OFFSET_Y:     off_y = signed'(val);
      default: ;
    endcase
  endtask

  task automatic apply_grid(input int cols, input int rows, input int ox, input int oy);
    write_reg(CFG_GRID_COLUMNS, CFG_W'(cols));
    write_reg(CFG_GRID_ROWS, CFG_W'(rows));
    write_reg(CFG_OFFSET_X, CFG_W'(ox));
    write_reg(CFG_OFFSET_Y, CFG_W'(oy));
  endtask

  // Wait for all commands to be taken and all pixels to arrive, then let the
  // block finish any step that emits nothing
  task automatic settle();
    do @(negedge clk);
    while (cmd_q.size() != 0 || s_axis_tvalid || pending_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // step with no line loaded
    push_cmd(OP_STEP, 0, 0, 0, 0, BRUSH_PLAIN);
    // extreme endpoints, swapped; first points lie off the grid
    push_cmd(OP_BEGIN, 511, 511, -512, -512, BRUSH_SPARE);
    push_cmd(OP_STEP, -512, -512, 511, 511, BRUSH_SPARE);
    push_cmd(OP_STEP, 511, -512, -512, 511, BRUSH_PLAIN);
    // begin during a line; shallow rising line, square brush inside the grid
    push_cmd(OP_BEGIN, 2, 3, 5, 4, BRUSH_SQUARE);
    push_steps(4);
    // steep falling line after the swap, cross brush
    push_cmd(OP_BEGIN, 5, 1, 4, 6, BRUSH_CROSS);
    push_steps(6);
    // steep rising, horizontal brush, dropped early
    push_cmd(OP_BEGIN, 0, 0, 1, 3, BRUSH_HORIZ);
    push_steps(2);
    // shallow falling, vertical brush
    push_cmd(OP_BEGIN, 0, 5, 3, 4, BRUSH_VERT);
    push_steps(2);
    // single point at the grid corner, brush code with no pattern: centre only
    push_cmd(OP_BEGIN, 15, 15, 15, 15, 3'd6);
    push_steps(1);
    random_lines(40);
    settle();

    apply_grid(512, 512, 0, 0);
    random_lines(40);
    settle();

    apply_grid(512, 512, 511, 511);
    random_lines(40);
    settle();

    apply_grid(1, 1, -200, 100);
    random_lines(35);
    settle();

    // oversized columns, zero rows: everything clipped
    apply_grid(1023, 0, -512, -512);
    random_lines(15);
    settle();

    apply_grid(1023, 1023, -5, 0);
    random_lines(40);
    settle();

    apply_grid($urandom_range(1, 512), $urandom_range(1, 512),
               int'($urandom_range(0, 1023)) - 512, int'($urandom_range(0, 1023)) - 512);
    random_lines(40);
    settle();

    if (err_cnt == 0 && pending_pixels.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/plr_pkg.sv
hdl/plr_stamp.sv
hdl/patterned_line_rasterizer.sv
hdl/plr_checker.sv
tb/sv/tb.sv
